// File: rtl/core/lpp_pkg.sv
`default_nettype none
package lpp_pkg;

	// width of every world and screen coordinate
	localparam int COORD_BITS = 16;

	// register indexes of the configuration port
	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_SCALE = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_GRID_UNITS   = 1'b1;

	localparam int SCALE_BITS = 16;
	localparam int UNITS_BITS = 12;
	localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd800;
	localparam logic [UNITS_BITS-1:0] UNITS_RESET = 12'd10;

	// internal datapath widths
	localparam int UZ_BITS  = COORD_BITS + 14;                  // u*(z+1)
	localparam int AW_BITS  = COORD_BITS + 18;                  // inner sums, divisor
	localparam int ZUZ_BITS = 2 * COORD_BITS + 14;              // z*u*(z+1)
	localparam int NW_A     = COORD_BITS + 35;
	localparam int NW_B     = 2 * COORD_BITS + 19;
	localparam int NW_BITS  = (NW_A > NW_B) ? NW_A : NW_B;      // numerators

	typedef struct packed {
		logic                          is_line;
		logic signed [COORD_BITS-1:0]  start_x;
		logic signed [COORD_BITS-1:0]  start_y;
		logic signed [COORD_BITS-1:0]  start_z;
		logic signed [COORD_BITS-1:0]  end_x;
		logic signed [COORD_BITS-1:0]  end_y;
		logic signed [COORD_BITS-1:0]  end_z;
	} in_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0]  screen_x1;
		logic signed [COORD_BITS-1:0]  screen_y1;
		logic signed [COORD_BITS-1:0]  screen_x2;
		logic signed [COORD_BITS-1:0]  screen_y2;
		logic                          bad_depth;
		logic                          clipped;
	} out_t;

	// status of one finished quotient
	typedef struct packed {
		logic zero;
		logic clip;
	} div_flags_t;

endpackage
`default_nettype wire

// File: rtl/core/line_perspective_projection_top.sv
`default_nettype none
// Perspective projection of line records.
// Input channel: in_valid / in_stall / in_data carry one record per beat. A
// record whose is_line bit is clear is dropped and yields no output beat.
// Output channel: out_valid / out_stall / out_data carry the four screen
// coordinates, the bad depth flag and the clip flag of one line record.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 screen
// scale, 1 grid units); write only while no record is in flight.
// Stages from input beat to output beat: three multiply stages, a range
// check, one stage per quotient bit of the four parallel restoring
// dividers, and a result stage. The whole pipeline is one stage chain.
// Throughput: one record per cycle while the output is not stalled.
// A stalled output holds the last stage and freezes every stage behind it,
// so in_stall is high exactly while an output beat waits under out_stall.
// Reset clears every valid bit and loads scale 800 and units 10; the data
// registers are not reset.
module line_perspective_projection_top
	import lpp_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire in_t                      in_data,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output out_t                          out_data,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [SCALE_BITS-1:0]    cfg_data
);

	localparam int LAT = COORD_BITS + 6;

	logic [SCALE_BITS-1:0] scale_q;
	logic [UNITS_BITS-1:0] units_q;
	logic [LAT-1:0]        valid_s;
	logic                  adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			units_q <= UNITS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCREEN_SCALE: scale_q <= cfg_data;
				REG_GRID_UNITS:   units_q <= cfg_data[UNITS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// advance the whole chain unless a finished beat is held
	assign adv      = !(valid_s[LAT-1] && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[LAT-2:0], in_valid && in_data.is_line};
		end
	end

	logic signed [NW_BITS-1:0] nx1, ny1, nx2, ny2;
	logic signed [AW_BITS-1:0] d1, d2;

	lpp_front u_front1 (
		.clk(clk), .en(adv), .scale(scale_q), .units(units_q),
		.x(in_data.start_x), .y(in_data.start_y), .z(in_data.start_z),
		.num_x(nx1), .num_y(ny1), .den(d1)
	);

	lpp_front u_front2 (
		.clk(clk), .en(adv), .scale(scale_q), .units(units_q),
		.x(in_data.end_x), .y(in_data.end_y), .z(in_data.end_z),
		.num_x(nx2), .num_y(ny2), .den(d2)
	);

	logic signed [COORD_BITS-1:0] qx1, qy1, qx2, qy2;
	div_flags_t fx1, fy1, fx2, fy2;

	lpp_div u_div_x1 (.clk(clk), .en(adv), .num(nx1), .den(d1), .quo(qx1), .flags(fx1));
	lpp_div u_div_y1 (.clk(clk), .en(adv), .num(ny1), .den(d1), .quo(qy1), .flags(fy1));
	lpp_div u_div_x2 (.clk(clk), .en(adv), .num(nx2), .den(d2), .quo(qx2), .flags(fx2));
	lpp_div u_div_y2 (.clk(clk), .en(adv), .num(ny2), .den(d2), .quo(qy2), .flags(fy2));

	// gather the four lanes into one beat
	always_comb begin
		out_data.screen_x1 = qx1;
		out_data.screen_y1 = qy1;
		out_data.screen_x2 = qx2;
		out_data.screen_y2 = qy2;
		out_data.bad_depth = fx1.zero || fx2.zero;
		out_data.clipped   = fx1.clip || fy1.clip || fx2.clip || fy2.clip;
	end

	assign out_valid = valid_s[LAT-1];

`ifndef NO_ASSERTIONS
	// an accepted line record enters the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.is_line |=> valid_s[0])
		else $error("accepted line record lost at entry");

	// a skipped record never enters
	a_skip: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !in_data.is_line |=> !valid_s[0])
		else $error("skipped record entered the pipeline");

	// a frozen chain keeps all its valid bits
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(valid_s))
		else $error("valid bits moved during a stall");

	// a zero divisor lane never reports a clip
	a_zero_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fx1.zero |-> !fx1.clip && !fy1.clip)
		else $error("clip raised on a zero divisor lane");
`endif

endmodule
`default_nettype wire

// File: rtl/core/lpp_front.sv
`default_nettype none
module lpp_front
	import lpp_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [SCALE_BITS-1:0]         scale,
	input  wire logic [UNITS_BITS-1:0]         units,
	input  wire logic signed [COORD_BITS-1:0]  x,
	input  wire logic signed [COORD_BITS-1:0]  y,
	input  wire logic signed [COORD_BITS-1:0]  z,
	output logic signed [NW_BITS-1:0]          num_x,
	output logic signed [NW_BITS-1:0]          num_y,
	output logic signed [AW_BITS-1:0]          den
);

	logic signed [UZ_BITS-1:0]    uz_s1;
	logic signed [COORD_BITS-1:0] x_s1, y_s1, z_s1;
	logic signed [AW_BITS-1:0]    ax_s2, ay_s2, d_s2;
	logic signed [ZUZ_BITS-1:0]   zuz_s2;
	logic signed [NW_BITS-1:0]    nx_s3, ny_s3;
	logic signed [AW_BITS-1:0]    d_s3;

	logic signed [UZ_BITS-1:0]  z1_w, u_w;
	logic signed [AW_BITS-1:0]  uz_e, u_e, x_e, y_e;
	logic signed [ZUZ_BITS-1:0] z_z, uz_z;
	logic signed [NW_BITS-1:0]  s_n, ax_n, ay_n, zuz_n;

	// stage 1: u*(z+1)
	always_comb begin
		z1_w = UZ_BITS'(z) + UZ_BITS'(1);
		u_w  = $signed(UZ_BITS'({1'b0, units}));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			uz_s1 <= u_w * z1_w;
			x_s1  <= x;
			y_s1  <= y;
			z_s1  <= z;
		end
	end

	// stage 2: inner sums, divisor, depth product
	always_comb begin
		uz_e = AW_BITS'(uz_s1);
		u_e  = $signed(AW_BITS'({1'b0, units}));
		x_e  = AW_BITS'(x_s1);
		y_e  = AW_BITS'(y_s1);
		z_z  = ZUZ_BITS'(z_s1);
		uz_z = ZUZ_BITS'(uz_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2  <= (uz_e <<< 1) + uz_e - (u_e <<< 1) + (x_e <<< 2);
			ay_s2  <= (uz_e <<< 1) + uz_e + (u_e <<< 1) - (y_e <<< 2);
			d_s2   <= (uz_e <<< 2) + (uz_e <<< 1);
			zuz_s2 <= z_z * uz_z;
		end
	end

	// stage 3: scale the sums and take the depth term off the y sum
	always_comb begin
		s_n   = $signed(NW_BITS'({1'b0, scale}));
		ax_n  = NW_BITS'(ax_s2);
		ay_n  = NW_BITS'(ay_s2);
		zuz_n = NW_BITS'(zuz_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s3 <= s_n * ax_n;
			ny_s3 <= s_n * ay_n - ((zuz_n <<< 3) + (zuz_n <<< 2));
			d_s3  <= d_s2;
		end
	end

	assign num_x = nx_s3;
	assign num_y = ny_s3;
	assign den   = d_s3;

endmodule
`default_nettype wire

// File: rtl/core/lpp_div.sv
`default_nettype none
module lpp_div
	import lpp_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [NW_BITS-1:0]     num,
	input  wire logic signed [AW_BITS-1:0]     den,
	output logic signed [COORD_BITS-1:0]       quo,
	output div_flags_t                         flags
);

	localparam int QB = COORD_BITS + 1;
	localparam int RW = NW_BITS + COORD_BITS + 2;
	localparam logic [QB-1:0] POS_MAX = QB'((2 ** (COORD_BITS - 1)) - 1);
	localparam logic [QB-1:0] NEG_MAX = QB'(2 ** (COORD_BITS - 1));

	logic [RW-1:0] rem_s  [0:QB];
	logic [RW-1:0] dv_s   [0:QB];
	logic [QB-1:0] q_s    [0:QB];
	logic          neg_s  [0:QB];
	logic          zero_s [0:QB];
	logic          ovf_s  [0:QB];

	logic [NW_BITS-1:0] an;
	logic [AW_BITS-1:0] ad;

	// magnitudes, sign and range check
	always_comb begin
		an = num[NW_BITS-1] ? NW_BITS'(-num) : NW_BITS'(num);
		ad = den[AW_BITS-1] ? AW_BITS'(-den) : AW_BITS'(den);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= RW'(an);
			dv_s[0]   <= RW'(ad);
			q_s[0]    <= '0;
			neg_s[0]  <= num[NW_BITS-1] ^ den[AW_BITS-1];
			zero_s[0] <= (ad == '0);
			ovf_s[0]  <= (RW'(an) >= (RW'(ad) << QB));
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < QB; k++) begin : g_step
		localparam int BIT = QB - 1 - k;
		logic [RW-1:0] trial;
		logic          take;

		always_comb begin
			trial = rem_s[k] - (dv_s[k] << BIT);
			take  = (rem_s[k] >= (dv_s[k] << BIT));
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? trial : rem_s[k];
				q_s[k+1]    <= q_s[k] | (take ? (QB'(1) << BIT) : '0);
				dv_s[k+1]   <= dv_s[k];
				neg_s[k+1]  <= neg_s[k];
				zero_s[k+1] <= zero_s[k];
				ovf_s[k+1]  <= ovf_s[k];
			end
		end
	end

	// sign, saturation and the zero divisor case
	logic [QB-1:0]           qm;
	logic                    sat;
	logic signed [COORD_BITS-1:0] qv;
	logic signed [COORD_BITS-1:0] quo_q;
	div_flags_t              flags_q;

	always_comb begin
		qm  = q_s[QB];
		sat = ovf_s[QB] || (neg_s[QB] ? (qm > NEG_MAX) : (qm > POS_MAX));
		if (zero_s[QB]) begin
			qv = '0;
		end else if (sat) begin
			qv = neg_s[QB] ? $signed({1'b1, {(COORD_BITS-1){1'b0}}})
			               : $signed({1'b0, {(COORD_BITS-1){1'b1}}});
		end else begin
			qv = neg_s[QB] ? COORD_BITS'(-qm) : COORD_BITS'(qm);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q        <= qv;
			flags_q.zero <= zero_s[QB];
			flags_q.clip <= sat && !zero_s[QB];
		end
	end

	assign quo   = quo_q;
	assign flags = flags_q;

endmodule
`default_nettype wire
